// ===== design/nnfr_pkg.sv =====
// Shared types and constants of the nearest-neighbour frame resizer.
// Used by the front end, the back end and the top level; depends on nothing.
package nnfr_pkg;

    localparam int DIM_W    = 9;
    localparam int PLANE_W  = 3;
    localparam int SCALE_W  = 24;
    localparam int PIX_W    = 8;
    localparam int COORD_W  = 8;
    localparam int CH_W     = 2;
    localparam int ADDR_W   = 20;
    localparam int PROD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int MAP_W    = PROD_W + 1 - FRAC_W;
    localparam int ROWSPAN_W = 2 * DIM_W;
    localparam int CFG_IDX_W = 3;

    localparam int CQ_DEPTH = 8;
    localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);
    localparam int OQ_DEPTH = 4;
    localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

    localparam logic [PROD_W:0] ROUND_HALF = (PROD_W + 1)'(32'h0000_8000);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_ROWS     = 3'd0,
        CFG_SRC_COLS     = 3'd1,
        CFG_NUM_CHANNELS = 3'd2,
        CFG_DST_ROWS     = 3'd3,
        CFG_DST_COLS     = 3'd4,
        CFG_SCALE_ROWS   = 3'd5,
        CFG_SCALE_COLS   = 3'd6
    } cfg_idx_t;

    typedef struct packed {
        logic [DIM_W-1:0]   src_rows;
        logic [DIM_W-1:0]   src_cols;
        logic [PLANE_W-1:0] num_channels;
        logic [DIM_W-1:0]   dst_rows;
        logic [DIM_W-1:0]   dst_cols;
        logic [SCALE_W-1:0] scale_rows;
        logic [SCALE_W-1:0] scale_cols;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        src_rows:     9'd28,
        src_cols:     9'd28,
        num_channels: 3'd1,
        dst_rows:     9'd28,
        dst_cols:     9'd28,
        scale_rows:   24'd65536,
        scale_cols:   24'd65536
    };

    typedef struct packed {
        logic              is_read;
        logic              err;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  pixel;
    } cmd_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             error;
    } res_t;

endpackage

// ===== design/nnfr_fifo.sv =====
// Small synchronous queue of packed items, register based.
// Used for the command queue and the result queue; needs no package.
module nnfr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [WIDTH-1:0]           wdata,
    input  logic                       pop,
    output logic [WIDTH-1:0]           rdata,
    output logic [$clog2(DEPTH+1)-1:0] count,
    output logic                       empty
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] data_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata = data_reg[rd_ptr_reg];
    assign count = count_reg;
    assign empty = (count_reg == '0);

endmodule

// ===== design/nnfr_front.sv =====
// Front end: accepts items, checks ranges, maps read coordinates and forms the store address.
// Depends on nnfr_pkg; feeds the command queue.
module nnfr_front #(
    parameter int MAX_DIM     = 256,
    parameter int MAX_PLANES  = 4,
    parameter int FRAME_WORDS = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  nnfr_pkg::cfg_t                 cfg,
    input  logic                           push,
    output logic                           full,
    input  logic                           action,
    input  logic [nnfr_pkg::COORD_W-1:0]   row,
    input  logic [nnfr_pkg::COORD_W-1:0]   col,
    input  logic [nnfr_pkg::CH_W-1:0]      channel,
    input  logic [nnfr_pkg::PIX_W-1:0]     pixel_in,
    input  logic [nnfr_pkg::CQ_CNT_W-1:0]  cq_count,
    output logic                           cmd_valid,
    output nnfr_pkg::cmd_t                 cmd
);
    import nnfr_pkg::*;

    localparam int DIM_CODE_MAX   = (1 << DIM_W) - 1;
    localparam int PLANE_CODE_MAX = (1 << PLANE_W) - 1;
    localparam logic [DIM_W-1:0] DIM_CAP =
        DIM_W'((MAX_DIM > DIM_CODE_MAX) ? DIM_CODE_MAX : MAX_DIM);
    localparam logic [PLANE_W-1:0] PLANE_CAP =
        PLANE_W'((MAX_PLANES > PLANE_CODE_MAX) ? PLANE_CODE_MAX : MAX_PLANES);
    localparam logic [ADDR_W:0] FRAME_LIMIT = (ADDR_W + 1)'(FRAME_WORDS);

    logic [DIM_W-1:0]   sr, sc, dr, dc;
    logic [PLANE_W-1:0] np;
    logic               take;
    logic               err_in;
    logic [CQ_CNT_W:0]  occupancy;

    logic [ROWSPAN_W-1:0] plane_reg;

    logic                 s1_valid_reg;
    logic                 s1_read_reg, s1_err_reg;
    logic [COORD_W-1:0]   s1_row_reg, s1_col_reg;
    logic [CH_W-1:0]      s1_ch_reg;
    logic [PIX_W-1:0]     s1_pix_reg;
    logic [PROD_W-1:0]    s1_prod_r_reg, s1_prod_c_reg;

    logic [MAP_W-1:0]     map_r, map_c;
    logic [DIM_W-1:0]     last_r, last_c;
    logic [DIM_W-1:0]     r_sel, c_sel;

    logic                 s2_valid_reg;
    logic                 s2_read_reg, s2_err_reg;
    logic [DIM_W-1:0]     s2_r_reg, s2_c_reg;
    logic [CH_W-1:0]      s2_ch_reg;
    logic [PIX_W-1:0]     s2_pix_reg;

    logic                 s3_valid_reg;
    logic                 s3_read_reg, s3_err_reg;
    logic [DIM_W-1:0]     s3_c_reg;
    logic [ROWSPAN_W-1:0] s3_rs_reg;
    logic [ADDR_W-1:0]    s3_cp_reg;
    logic [PIX_W-1:0]     s3_pix_reg;

    logic [ADDR_W:0]      addr_sum;

    always_comb
    begin
        sr = (cfg.src_rows > DIM_CAP) ? DIM_CAP : cfg.src_rows;
        sc = (cfg.src_cols > DIM_CAP) ? DIM_CAP : cfg.src_cols;
        dr = (cfg.dst_rows > DIM_CAP) ? DIM_CAP : cfg.dst_rows;
        dc = (cfg.dst_cols > DIM_CAP) ? DIM_CAP : cfg.dst_cols;
        np = (cfg.num_channels > PLANE_CAP) ? PLANE_CAP : cfg.num_channels;
    end

    assign occupancy = (CQ_CNT_W + 1)'(cq_count) + (CQ_CNT_W + 1)'(s1_valid_reg)
                     + (CQ_CNT_W + 1)'(s2_valid_reg) + (CQ_CNT_W + 1)'(s3_valid_reg);
    assign full = (occupancy >= (CQ_CNT_W + 1)'(CQ_DEPTH));
    assign take = push && !full;

    always_comb
    begin
        if (action)
        begin
            err_in = (DIM_W'(row) >= dr) || (DIM_W'(col) >= dc)
                  || (PLANE_W'(channel) >= np) || (sr == '0) || (sc == '0);
        end
        else
        begin
            err_in = (DIM_W'(row) >= sr) || (DIM_W'(col) >= sc)
                  || (PLANE_W'(channel) >= np);
        end
    end

    always_comb
    begin
        map_r  = MAP_W'(((PROD_W + 1)'(s1_prod_r_reg) + ROUND_HALF) >> FRAC_W);
        map_c  = MAP_W'(((PROD_W + 1)'(s1_prod_c_reg) + ROUND_HALF) >> FRAC_W);
        last_r = sr - 1'b1;
        last_c = sc - 1'b1;
        if (s1_read_reg)
        begin
            r_sel = (map_r > MAP_W'(last_r)) ? last_r : map_r[DIM_W-1:0];
            c_sel = (map_c > MAP_W'(last_c)) ? last_c : map_c[DIM_W-1:0];
        end
        else
        begin
            r_sel = DIM_W'(s1_row_reg);
            c_sel = DIM_W'(s1_col_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= take;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        plane_reg     <= ROWSPAN_W'(sr) * ROWSPAN_W'(sc);

        s1_read_reg   <= action;
        s1_err_reg    <= err_in;
        s1_row_reg    <= row;
        s1_col_reg    <= col;
        s1_ch_reg     <= channel;
        s1_pix_reg    <= pixel_in;
        s1_prod_r_reg <= PROD_W'(row) * PROD_W'(cfg.scale_rows);
        s1_prod_c_reg <= PROD_W'(col) * PROD_W'(cfg.scale_cols);

        s2_read_reg   <= s1_read_reg;
        s2_err_reg    <= s1_err_reg;
        s2_r_reg      <= r_sel;
        s2_c_reg      <= c_sel;
        s2_ch_reg     <= s1_ch_reg;
        s2_pix_reg    <= s1_pix_reg;

        s3_read_reg   <= s2_read_reg;
        s3_err_reg    <= s2_err_reg;
        s3_c_reg      <= s2_c_reg;
        s3_rs_reg     <= ROWSPAN_W'(s2_r_reg) * ROWSPAN_W'(sc);
        s3_cp_reg     <= ADDR_W'(s2_ch_reg) * ADDR_W'(plane_reg);
        s3_pix_reg    <= s2_pix_reg;
    end

    assign addr_sum = (ADDR_W + 1)'(s3_c_reg) + (ADDR_W + 1)'(s3_rs_reg)
                    + (ADDR_W + 1)'(s3_cp_reg);

    always_comb
    begin
        cmd_valid   = s3_valid_reg;
        cmd.is_read = s3_read_reg;
        cmd.err     = s3_err_reg || (addr_sum >= FRAME_LIMIT);
        cmd.addr    = addr_sum[ADDR_W-1:0];
        cmd.pixel   = s3_pix_reg;
    end

endmodule

// ===== design/nnfr_back.sv =====
// Back end: frame store memory, carries out writes and reads from the command queue.
// Depends on nnfr_pkg; feeds the result queue.
module nnfr_back #(
    parameter int FRAME_WORDS = 65536
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cq_empty,
    input  nnfr_pkg::cmd_t                 cmd,
    output logic                           cq_pop,
    input  logic [nnfr_pkg::OQ_CNT_W-1:0]  oq_count,
    output logic                           res_valid,
    output nnfr_pkg::res_t                 res
);
    import nnfr_pkg::*;

    localparam int AW = $clog2(FRAME_WORDS);

    logic [PIX_W-1:0] store_mem [FRAME_WORDS];
    logic [AW-1:0]    mem_addr;
    logic             store_we;
    logic [OQ_CNT_W:0] occupancy;

    logic             b_valid_reg;
    logic             b_hit_reg, b_err_reg;
    logic [PIX_W-1:0] rd_data_reg;

    assign occupancy = (OQ_CNT_W + 1)'(oq_count) + (OQ_CNT_W + 1)'(b_valid_reg);
    assign cq_pop    = !cq_empty && (occupancy < (OQ_CNT_W + 1)'(OQ_DEPTH));
    assign mem_addr  = cmd.addr[AW-1:0];
    assign store_we  = cq_pop && !cmd.is_read && !cmd.err;

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_mem[mem_addr] <= cmd.pixel;
        end
        else if (cq_pop)
        begin
            rd_data_reg <= store_mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else
        begin
            b_valid_reg <= cq_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        b_hit_reg <= cmd.is_read && !cmd.err;
        b_err_reg <= cmd.err;
    end

    always_comb
    begin
        res_valid = b_valid_reg;
        res.pixel = b_hit_reg ? rd_data_reg : '0;
        res.error = b_err_reg;
    end

endmodule

// ===== design/nearest_neighbor_frame_resizer_core.sv =====
// Nearest-neighbour frame resizer, top level: configuration registers, queues, front and back.
// Depends on nnfr_pkg, nnfr_fifo, nnfr_front and nnfr_back.
//
// Input channel: push/full. A write item (action 0) stores pixel_in at (row, col, channel)
// of the planar source frame; a read item (action 1) names a destination pixel whose
// nearest source pixel comes back, mapped with align-corners scaling in Q8.16.
// Result channel: empty/pop. One result per item, in order: pixel_out and error.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is always high.
// Write registers only while no item is in flight.
// Throughput: one item per cycle while full stays low, set by the single-port frame store in the back end,
// which serves one write or one read each cycle.
// The front pipeline reserves room in the command queue, so full rises only when the
// queue backs up; the back end stops taking commands when the result queue is full.
// A stalled receiver therefore fills the result queue, then the command queue, then full.
// Reset clears the queues and the pipeline and loads the register defaults; the frame
// store keeps no reset and holds undefined data until written.
module nearest_neighbor_frame_resizer_core #(
    parameter int MAX_DIM     = 256,
    parameter int MAX_PLANES  = 4,
    parameter int FRAME_WORDS = 65536
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic                            action,
    input  logic [nnfr_pkg::COORD_W-1:0]    row,
    input  logic [nnfr_pkg::COORD_W-1:0]    col,
    input  logic [nnfr_pkg::CH_W-1:0]       channel,
    input  logic [nnfr_pkg::PIX_W-1:0]      pixel_in,
    output logic                            empty,
    input  logic                            pop,
    output logic [nnfr_pkg::PIX_W-1:0]      pixel_out,
    output logic                            error,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [nnfr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nnfr_pkg::SCALE_W-1:0]    cfg_data
);
    import nnfr_pkg::*;

    cfg_t cfg_reg, cfg_next;

    logic              cmd_valid;
    cmd_t              cmd_front;
    cmd_t              cmd_head;
    logic              cq_pop;
    logic              cq_empty;
    logic [CQ_CNT_W-1:0] cq_count;

    logic              res_valid;
    res_t              res_back;
    res_t              res_head;
    logic              oq_pop;
    logic [OQ_CNT_W-1:0] oq_count;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_SRC_ROWS:     cfg_next.src_rows     = cfg_data[DIM_W-1:0];
                CFG_SRC_COLS:     cfg_next.src_cols     = cfg_data[DIM_W-1:0];
                CFG_NUM_CHANNELS: cfg_next.num_channels = cfg_data[PLANE_W-1:0];
                CFG_DST_ROWS:     cfg_next.dst_rows     = cfg_data[DIM_W-1:0];
                CFG_DST_COLS:     cfg_next.dst_cols     = cfg_data[DIM_W-1:0];
                CFG_SCALE_ROWS:   cfg_next.scale_rows   = cfg_data;
                CFG_SCALE_COLS:   cfg_next.scale_cols   = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    nnfr_front #(
        .MAX_DIM     (MAX_DIM),
        .MAX_PLANES  (MAX_PLANES),
        .FRAME_WORDS (FRAME_WORDS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .push      (push),
        .full      (full),
        .action    (action),
        .row       (row),
        .col       (col),
        .channel   (channel),
        .pixel_in  (pixel_in),
        .cq_count  (cq_count),
        .cmd_valid (cmd_valid),
        .cmd       (cmd_front)
    );

    nnfr_fifo #(
        .WIDTH ($bits(cmd_t)),
        .DEPTH (CQ_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (cmd_valid),
        .wdata (cmd_front),
        .pop   (cq_pop),
        .rdata (cmd_head),
        .count (cq_count),
        .empty (cq_empty)
    );

    nnfr_back #(
        .FRAME_WORDS (FRAME_WORDS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cq_empty  (cq_empty),
        .cmd       (cmd_head),
        .cq_pop    (cq_pop),
        .oq_count  (oq_count),
        .res_valid (res_valid),
        .res       (res_back)
    );

    assign oq_pop = pop && !empty;

    nnfr_fifo #(
        .WIDTH ($bits(res_t)),
        .DEPTH (OQ_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_valid),
        .wdata (res_back),
        .pop   (oq_pop),
        .rdata (res_head),
        .count (oq_count),
        .empty (empty)
    );

    assign pixel_out = res_head.pixel;
    assign error     = res_head.error;

endmodule
